/* src/lga_pkg.sv */
// shared types and constants for the lpt job assigner
// no dependencies
`default_nettype none
package lga_pkg;
   localparam int SIZE_W = 40;
   localparam int COST_W = 41;
   localparam int LOAD_W = 47;
   localparam int TAG_W = 6;
   localparam int WID_W = 4;
   localparam int CNT_W = 5;
   localparam logic [COST_W-1:0] JOB_OVERHEAD = 41'd32768;

   typedef struct packed {
      logic [COST_W-1:0] cost;
      logic [TAG_W-1:0]  tag;
      logic              last;
   } job_type;
endpackage
`default_nettype wire

/* src/lga_front.sv */
// front end: takes requests, computes cost, queues them for the back end
// depends on lga_pkg
`default_nettype none
module lga_front
   import lga_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              take,
   input  wire logic [SIZE_W-1:0] size,
   input  wire logic [TAG_W-1:0]  tag,
   input  wire logic              last,
   input  wire logic              pop,
   output job_type                head,
   output logic                   not_empty,
   output logic                   full
);
   // two entry queue
   job_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   job_type nj;
   logic to_head;

   always_comb begin
      nj.cost = {1'b0, size} + JOB_OVERHEAD;
      nj.tag = tag;
      nj.last = last;
      cnt_in = cnt_ff + 2'(take) - 2'(pop);
      // new request lands in slot 0 when the queue is or becomes empty
      to_head = (cnt_ff == 2'd0) || (pop && (cnt_ff == 2'd1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (take && to_head) begin
         q_ff[0] <= nj;
      end else if (pop) begin
         q_ff[0] <= q_ff[1];
      end
      if (take && !to_head) begin
         q_ff[1] <= nj;
      end
   end

   assign head = q_ff[0];
   assign not_empty = cnt_ff != 2'd0;
   assign full = cnt_ff == 2'd2;
endmodule
`default_nettype wire

/* src/lga_back.sv */
// back end: stores jobs, sorts them by insertion as they arrive, assigns workers
// depends on lga_pkg
`default_nettype none
module lga_back
   import lga_pkg::*;
#(
   parameter int MAX_JOBS = 64,
   parameter int MAX_WORKERS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [CNT_W-1:0] workers,
   input  wire job_type          head,
   input  wire logic             not_empty,
   output logic                  pop,
   output logic                  rsp_valid,
   output logic [TAG_W-1:0]      rsp_out_tag,
   output logic [WID_W-1:0]      rsp_assigned_worker,
   output logic                  rsp_overflow,
   output logic                  rsp_last_result
);
   localparam int JI_W = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int JC_W = $clog2(MAX_JOBS + 1);
   localparam int WI_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int WC_W = $clog2(MAX_WORKERS + 1);
   localparam logic [2:0] S_LOAD = 3'd0, S_SCAN = 3'd1, S_FIND = 3'd2,
      S_ADD = 3'd3, S_SHIFT = 3'd4, S_READ = 3'd5;

   // jobs are kept sorted by insertion as they arrive; each entry moves through a read state and a shift state
   logic [COST_W-1:0] cost_ff [MAX_JOBS];
   logic [TAG_W-1:0]  tag_ff  [MAX_JOBS];
   logic [LOAD_W-1:0] load_ff [MAX_WORKERS];
   logic [2:0] st_ff;
   logic [JC_W-1:0] n_ff, i_ff;
   logic [JI_W-1:0] ins_ff;
   logic [WC_W-1:0] w_ff, nw_ff;
   logic [WI_W-1:0] best_ff;
   logic drop_ff, fin_ff;
   job_type pend_ff;
   logic [TAG_W-1:0] otag_ff;
   logic [WID_W-1:0] owk_ff;
   logic ov_ff, ol_ff, ov_ff2;
   logic [COST_W-1:0] ccost_ff;
   logic [COST_W-1:0] rd_cost_ff;
   logic [TAG_W-1:0]  rd_tag_ff;
   logic goes;

   // pending job precedes stored entry ins-1 (read into rd_*)
   always_comb begin
      goes = (pend_ff.cost > rd_cost_ff) ||
         ((pend_ff.cost == rd_cost_ff) && (pend_ff.tag < rd_tag_ff));
   end

   assign pop = (st_ff == S_LOAD) && not_empty && !fin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_LOAD;
         n_ff <= '0;
         drop_ff <= 1'b0;
         fin_ff <= 1'b0;
         ov_ff <= 1'b0;
         for (int k = 0; k < MAX_WORKERS; k++) load_ff[k] <= '0;
      end else begin
         ov_ff <= 1'b0;
         case (st_ff)
            S_LOAD: begin
               if (fin_ff) begin
                  fin_ff <= 1'b0;
                  i_ff <= '0;
                  nw_ff <= (workers == '0) ? WC_W'(1) :
                     ((32'(workers) > MAX_WORKERS) ? WC_W'(MAX_WORKERS) :
                      WC_W'(workers));
                  for (int k = 0; k < MAX_WORKERS; k++) load_ff[k] <= '0;
                  if (n_ff == '0) begin
                     drop_ff <= 1'b0;
                  end else begin
                     st_ff <= S_FIND;
                     w_ff <= WC_W'(1);
                     best_ff <= '0;
                  end
               end else if (pop) begin
                  fin_ff <= head.last;
                  if (32'(n_ff) < MAX_JOBS) begin
                     pend_ff <= head;
                     ins_ff <= JI_W'(n_ff);
                     n_ff <= n_ff + JC_W'(1);
                     st_ff <= S_READ;
                  end else begin
                     drop_ff <= 1'b1;
                  end
               end
            end
            S_READ: begin
               if (ins_ff == '0) begin
                  cost_ff[ins_ff] <= pend_ff.cost;
                  tag_ff[ins_ff] <= pend_ff.tag;
                  st_ff <= S_LOAD;
               end else begin
                  rd_cost_ff <= cost_ff[ins_ff - JI_W'(1)];
                  rd_tag_ff <= tag_ff[ins_ff - JI_W'(1)];
                  st_ff <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (goes) begin
                  cost_ff[ins_ff] <= rd_cost_ff;
                  tag_ff[ins_ff] <= rd_tag_ff;
                  ins_ff <= ins_ff - JI_W'(1);
                  st_ff <= S_READ;
               end else begin
                  cost_ff[ins_ff] <= pend_ff.cost;
                  tag_ff[ins_ff] <= pend_ff.tag;
                  st_ff <= S_LOAD;
               end
            end
            S_FIND: begin
               if (w_ff < nw_ff) begin
                  if (load_ff[WI_W'(w_ff)] < load_ff[best_ff]) best_ff <= WI_W'(w_ff);
                  w_ff <= w_ff + WC_W'(1);
               end else begin
                  st_ff <= S_ADD;
                  ccost_ff <= cost_ff[JI_W'(i_ff)];
                  otag_ff <= tag_ff[JI_W'(i_ff)];
               end
            end
            S_ADD: begin
               load_ff[best_ff] <= load_ff[best_ff] + LOAD_W'(ccost_ff);
               owk_ff <= WID_W'(best_ff);
               ov_ff <= 1'b1;
               ov_ff2 <= drop_ff;
               ol_ff <= (i_ff + JC_W'(1) == n_ff);
               i_ff <= i_ff + JC_W'(1);
               if (i_ff + JC_W'(1) == n_ff) begin
                  st_ff <= S_LOAD;
                  n_ff <= '0;
                  drop_ff <= 1'b0;
               end else begin
                  st_ff <= S_FIND;
                  w_ff <= WC_W'(1);
                  best_ff <= '0;
               end
            end
            default: st_ff <= S_LOAD;
         endcase
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_out_tag = otag_ff;
   assign rsp_assigned_worker = owk_ff;
   assign rsp_overflow = ov_ff2;
   assign rsp_last_result = ol_ff;
endmodule
`default_nettype wire

/* src/lpt_greedy_job_assigner_top.sv */
// Longest-processing-time-first job assigner. A request is taken when start is
// high and busy is low; results appear one per rsp_valid strobe and
// cannot be stalled. A request waits in a two-entry queue (busy is high only
// while it is full), then is loaded by an insertion sort that reads one stored
// entry and writes it back one slot up until the request reaches its place;
// a request dropped because the batch is full is not stored. Assignment starts
// once the last job is loaded, and each result comes from a serial least-loaded
// search over the worker loads, up to the worker count (held to 1..MAX_WORKERS).
// depends on lga_pkg, lga_front, lga_back
`default_nettype none
module lpt_greedy_job_assigner_top
   import lga_pkg::*;
#(
   parameter int MAX_JOBS = 64,
   parameter int MAX_WORKERS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [SIZE_W-1:0] req_job_size,
   input  wire logic [TAG_W-1:0]  req_job_tag,
   input  wire logic              req_last_job,
   input  wire logic              csr_we,
   input  wire logic [CNT_W-1:0]  csr_wdata,
   output logic                   rsp_valid,
   output logic [TAG_W-1:0]       rsp_out_tag,
   output logic [WID_W-1:0]       rsp_assigned_worker,
   output logic                   rsp_overflow,
   output logic                   rsp_last_result
);
   logic [CNT_W-1:0] wc_ff;
   job_type head;
   logic not_empty, full, pop;

   always_ff @(posedge clock) begin
      if (reset) wc_ff <= CNT_W'(1);
      else if (csr_we) wc_ff <= csr_wdata;
   end

   assign busy = full;

   lga_front u_front (
      .clock, .reset, .take(start && !busy), .size(req_job_size),
      .tag(req_job_tag), .last(req_last_job), .pop, .head, .not_empty, .full
   );

   lga_back #(.MAX_JOBS(MAX_JOBS), .MAX_WORKERS(MAX_WORKERS)) u_back (
      .clock, .reset, .workers(wc_ff), .head, .not_empty, .pop,
      .rsp_valid, .rsp_out_tag, .rsp_assigned_worker, .rsp_overflow,
      .rsp_last_result
   );
endmodule
`default_nettype wire

/* src/lga_checker.sv */
// port-level checks for the job assigner
// depends on lpt_greedy_job_assigner_top ports
`default_nettype none
module lga_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire logic rsp_last_result
);
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results too close");
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !busy) else $error("active after reset");
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_result |=> !rsp_valid ##1 !rsp_valid)
      else $error("result after batch end");
endmodule

bind lpt_greedy_job_assigner_top lga_checker u_chk (
   .clock, .reset, .busy, .rsp_valid, .rsp_last_result
);
`default_nettype wire
